// ===== src/grid_dda_column_raycaster_assert.svh =====
// assertion macros shared by the raycaster rtl
`ifndef GRID_DDA_COLUMN_RAYCASTER_ASSERT_SVH
`define GRID_DDA_COLUMN_RAYCASTER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during rst
`define GDDR_AST_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GDDR_AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gddr_pkg.sv =====
// shared constants, types and the wall palette of the raycaster
package gddr_pkg;

  localparam int SCREEN_W_DEF  = 320;
  localparam int SCREEN_H_DEF  = 240;
  localparam int MAP_SIDE_DEF  = 32;
  localparam int MAX_STEPS_DEF = 64;

  localparam int DIV_NUM_W = 32;

  localparam logic [21:0] DIST_MAX  = 22'h3FFFFF;
  localparam logic [40:0] DELTA_INF = 41'h100_0000_0000;
  localparam logic [31:0] INV_NUM   = 32'h4000_0000;

  localparam logic [20:0] POS_RST   = 21'd98304;
  localparam logic [15:0] DIR_X_RST = 16'hC000;
  localparam logic [15:0] DIR_Y_RST = 16'h0000;
  localparam logic [15:0] PLN_X_RST = 16'h0000;
  localparam logic [15:0] PLN_Y_RST = 16'd10813;

  typedef enum logic [2:0] {
    CFG_POS_X   = 3'd0,
    CFG_POS_Y   = 3'd1,
    CFG_DIR_X   = 3'd2,
    CFG_DIR_Y   = 3'd3,
    CFG_PLANE_X = 3'd4,
    CFG_PLANE_Y = 3'd5
  } cfg_idx_t;

  typedef enum logic [7:0] {
    WALL_RED   = 8'd1,
    WALL_GREEN = 8'd2,
    WALL_BLUE  = 8'd3,
    WALL_WHITE = 8'd4
  } wall_code_t;

  // {red, green, blue}
  function automatic logic [23:0] wall_rgb(input logic [7:0] code);
    logic [23:0] rgb;
    case (code)
      WALL_RED:   rgb = 24'hFF0000;
      WALL_GREEN: rgb = 24'h00FF00;
      WALL_BLUE:  rgb = 24'h0000FF;
      WALL_WHITE: rgb = 24'hFFFFFF;
      default:    rgb = 24'hFFFF00;
    endcase
    return rgb;
  endfunction

endpackage

// ===== src/gddr_ram.sv =====
// generic single-port-write, registered-read ram
module gddr_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);
  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/gddr_div.sv =====
// restoring divider, one quotient bit per cycle
module gddr_div #(
  parameter int NUM_W = gddr_pkg::DIV_NUM_W,
  parameter int DEN_W = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem, quot[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt   <= CNT_W'(NUM_W);
        rem   <= '0;
        quot  <= num;
        den_q <= den;
      end else if (cnt != '0) begin
        rem  <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
        quot <= {quot[NUM_W-2:0], ge};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== src/grid_dda_column_raycaster.sv =====
// Column raycaster over a MAP_SIDE x MAP_SIDE byte map held in one ram.
// After reset the map is swept to zero, one cell a cycle (MAP_SIDE*MAP_SIDE
// cells, 1024 at defaults); busy is high during the sweep and config writes
// are still taken. A cast forms its camera value with a constant reciprocal
// multiply, then runs up to three divisions on one shared bit-serial divider
// (two reciprocals and the line height) and walks the grid cell by cell: a
// walk state issues the ram read and a probe state tests the cell. With no
// wall or at zero distance the height division is skipped. Each cast with
// a column below SCREEN_W gives one result: done is high for exactly one
// cycle and the result must be taken then, since the receiver cannot
// stall the block.
module grid_dda_column_raycaster #(
  parameter int SCREEN_W  = gddr_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H  = gddr_pkg::SCREEN_H_DEF,
  parameter int MAP_SIDE  = gddr_pkg::MAP_SIDE_DEF,
  parameter int MAX_STEPS = gddr_pkg::MAX_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [8:0]  column,
  input  logic [4:0]  cell_x,
  input  logic [4:0]  cell_y,
  input  logic [7:0]  cell_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [20:0] cfg_data,
  output logic        done,
  output logic [8:0]  out_column,
  output logic [7:0]  draw_start,
  output logic [7:0]  draw_end,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        hit_side,
  output logic [4:0]  hit_cell_x,
  output logic [4:0]  hit_cell_y,
  output logic [21:0] wall_distance,
  output logic        no_wall
);
  import gddr_pkg::*;
  `include "grid_dda_column_raycaster_assert.svh"

  localparam int DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAP_SIDE);
  localparam int MC_W  = CW + 2;
  localparam int SC_W  = $clog2(MAX_STEPS);
  localparam int B_W   = 42 + $clog2(MAX_STEPS + 1);
  localparam logic signed [MC_W-1:0] MAP_S = MC_W'(MAP_SIDE);
  localparam logic [31:0] HGT_NUM  = 32'(SCREEN_H * 65536);
  localparam logic [31:0] HGT_ZERO = 32'(SCREEN_H * 131072);
  localparam logic [31:0] HALF_H   = 32'(SCREEN_H / 2);
  // camera numerator below 2^27; reciprocal exact for every such numerator
  localparam int CAM_N  = 27;
  localparam int CAM_S  = CAM_N + $clog2(SCREEN_W);
  localparam int CAM_MW = CAM_N + 2;
  localparam logic [CAM_MW-1:0] CAM_M =
    CAM_MW'(((64'd1 << CAM_S) + 64'(SCREEN_W) - 64'd1) / 64'(SCREEN_W));

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CAM, ST_MUL, ST_ADD, ST_DX, ST_DY,
    ST_BND, ST_WALK, ST_PROBE, ST_HGT, ST_FINISH
  } state_t;

  state_t state;

  logic [20:0]        pos_x, pos_y;
  logic signed [15:0] dir_x, dir_y, plane_x, plane_y;

  logic [AW-1:0]      clr_addr;
  logic [8:0]         col_q;
  logic               cam_neg;
  logic [CAM_N-1:0]   cam_num;
  logic signed [14:0] cam;
  logic signed [30:0] prod_x, prod_y;
  logic signed [17:0] rx, ry;
  logic [40:0]        dx, dy;
  logic [B_W-1:0]     bx, by, dist_q;
  logic signed [MC_W-1:0] mx, my;
  logic               hit_y, found;
  logic [SC_W-1:0]    steps;
  logic [7:0]         hit_val;
  logic [31:0]        lh;

  logic               div_go, div_done;
  logic [31:0]        div_num, div_quot;
  logic [B_W-1:0]     div_den;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [7:0]         ram_wdata, ram_rdata;

  // combinational helpers
  logic [13:0]        col2, sw14, cam_mag14;
  logic               col_ok, cam_lt, cell_ok, user_wr, in_map;
  logic [55:0]        cam_prod;
  logic [14:0]        cam_quo;
  logic signed [17:0] rx_sum, ry_sum;
  logic [17:0]        rx_mag, ry_mag;
  logic [16:0]        fx, fy;
  logic [47:0]        mul_x, mul_y;
  logic               step_x, out_n;
  logic signed [MC_W-1:0] mx_n, my_n;
  logic [B_W-1:0]     dist_n;
  logic [30:0]        half;
  logic [31:0]        de_raw;
  logic [23:0]        rgb;

  assign busy      = state != ST_IDLE;
  assign cfg_ready = 1'b1;

  assign col2      = {4'd0, column, 1'b0};
  assign sw14      = 14'(SCREEN_W);
  assign col_ok    = {5'd0, column} < sw14;
  assign cam_lt    = col2 < sw14;
  assign cam_mag14 = cam_lt ? sw14 - col2 : col2 - sw14;
  // quotient by SCREEN_W; negative side rounds the magnitude up for the floor
  assign cam_prod  = 56'(cam_num) * 56'(CAM_M);
  assign cam_quo   = 15'(cam_prod >> CAM_S);

  assign cell_ok = (32'(cell_x) < MAP_SIDE) && (32'(cell_y) < MAP_SIDE);
  assign user_wr = start && !busy && !mode && cell_ok;
  assign in_map  = (32'(pos_x[20:16]) < MAP_SIDE) && (32'(pos_y[20:16]) < MAP_SIDE);

  assign rx_sum = 18'(dir_x) + 18'(prod_x >>> 14);
  assign ry_sum = 18'(dir_y) + 18'(prod_y >>> 14);
  assign rx_mag = rx_sum[17] ? 18'(-rx_sum) : 18'(rx_sum);
  assign ry_mag = ry[17] ? 18'(-ry) : 18'(ry);
  assign fx = rx[17] ? {1'b0, pos_x[15:0]} : 17'h10000 - {1'b0, pos_x[15:0]};
  assign fy = ry[17] ? {1'b0, pos_y[15:0]} : 17'h10000 - {1'b0, pos_y[15:0]};
  assign mul_x = 48'(fx) * 48'(dx[30:0]);
  assign mul_y = 48'(fy) * 48'(dy[30:0]);

  // one dda step: advance x only if its boundary is strictly nearer, else y (y wins a tie)
  assign step_x = bx < by;
  assign mx_n = step_x ? (rx[17] ? mx - 1'b1 : mx + 1'b1) : mx;
  assign my_n = step_x ? my : (ry[17] ? my - 1'b1 : my + 1'b1);
  assign out_n = mx_n < 0 || my_n < 0 || mx_n >= MAP_S || my_n >= MAP_S;

  assign dist_n = hit_y ? by - B_W'(dy) : bx - B_W'(dx);

  assign half   = lh[31:1];
  assign de_raw = 32'(half) + HALF_H;
  assign rgb    = wall_rgb(hit_val);

  assign ram_raddr = AW'(AW'(my_n[CW-1:0]) * AW'(MAP_SIDE)) + AW'(mx_n[CW-1:0]);
  assign ram_we    = (state == ST_CLEAR) || user_wr;
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr
                   : AW'(32'(cell_y) * MAP_SIDE + 32'(cell_x));
  assign ram_wdata = (state == ST_CLEAR) ? 8'd0 : cell_value;

  gddr_ram #(.DATA_W(8), .DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gddr_div #(.NUM_W(DIV_NUM_W), .DEN_W(B_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      div_go   <= 1'b0;
      done     <= 1'b0;
      pos_x    <= POS_RST;
      pos_y    <= POS_RST;
      dir_x    <= DIR_X_RST;
      dir_y    <= DIR_Y_RST;
      plane_x  <= PLN_X_RST;
      plane_y  <= PLN_Y_RST;
    end else begin
      div_go <= 1'b0;
      done   <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_POS_X:   pos_x   <= cfg_data;
          CFG_POS_Y:   pos_y   <= cfg_data;
          CFG_DIR_X:   dir_x   <= cfg_data[15:0];
          CFG_DIR_Y:   dir_y   <= cfg_data[15:0];
          CFG_PLANE_X: plane_x <= cfg_data[15:0];
          CFG_PLANE_Y: plane_y <= cfg_data[15:0];
          default: ;
        endcase
      end

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start && mode && col_ok) begin
            col_q   <= column;
            cam_neg <= cam_lt;
            steps   <= '0;
            cam_num <= cam_lt ? 27'({cam_mag14, 14'd0}) + 27'(SCREEN_W - 1)
                              : 27'({cam_mag14, 14'd0});
            state   <= ST_CAM;
          end
        end
        ST_CAM: begin
          cam   <= cam_neg ? 15'(16'd0 - 16'(cam_quo)) : cam_quo;
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod_x <= plane_x * cam;
          prod_y <= plane_y * cam;
          state  <= ST_ADD;
        end
        ST_ADD: begin
          rx      <= rx_sum;
          ry      <= ry_sum;
          div_num <= INV_NUM;
          div_den <= B_W'(rx_mag);
          div_go  <= 1'b1;
          state   <= ST_DX;
        end
        ST_DX: begin
          if (div_done) begin
            dx      <= (rx == '0) ? DELTA_INF : 41'(div_quot);
            div_num <= INV_NUM;
            div_den <= B_W'(ry_mag);
            div_go  <= 1'b1;
            state   <= ST_DY;
          end
        end
        ST_DY: begin
          if (div_done) begin
            dy    <= (ry == '0) ? DELTA_INF : 41'(div_quot);
            state <= ST_BND;
          end
        end
        ST_BND: begin
          bx <= dx[40] ? B_W'({fx, 24'd0}) : B_W'(mul_x[47:16]);
          by <= dy[40] ? B_W'({fy, 24'd0}) : B_W'(mul_y[47:16]);
          mx <= MC_W'(pos_x[20:16]);
          my <= MC_W'(pos_y[20:16]);
          if (in_map) begin
            state <= ST_WALK;
          end else begin
            found <= 1'b0;
            state <= ST_FINISH;
          end
        end
        ST_WALK: begin
          if (step_x) begin
            bx <= bx + B_W'(dx);
          end else begin
            by <= by + B_W'(dy);
          end
          mx    <= mx_n;
          my    <= my_n;
          hit_y <= !step_x;
          if (out_n) begin
            found <= 1'b0;
            state <= ST_FINISH;
          end else begin
            state <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (ram_rdata != 8'd0) begin
            found   <= 1'b1;
            hit_val <= ram_rdata;
            dist_q  <= dist_n;
            if (dist_n == '0) begin
              lh    <= HGT_ZERO;
              state <= ST_FINISH;
            end else begin
              div_num <= HGT_NUM;
              div_den <= dist_n;
              div_go  <= 1'b1;
              state   <= ST_HGT;
            end
          end else if (steps == SC_W'(MAX_STEPS - 1)) begin
            found <= 1'b0;
            state <= ST_FINISH;
          end else begin
            steps <= steps + 1'b1;
            state <= ST_WALK;
          end
        end
        ST_HGT: begin
          if (div_done) begin
            lh    <= div_quot;
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          done       <= 1'b1;
          out_column <= col_q;
          if (found) begin
            draw_start    <= (32'(half) >= HALF_H) ? 8'd0 : 8'(HALF_H - 32'(half));
            draw_end      <= (de_raw >= 32'(SCREEN_H)) ? 8'(SCREEN_H - 1) : 8'(de_raw);
            red           <= hit_y ? {1'b0, rgb[23:17]} : rgb[23:16];
            green         <= hit_y ? {1'b0, rgb[15:9]}  : rgb[15:8];
            blue          <= hit_y ? {1'b0, rgb[7:1]}   : rgb[7:0];
            hit_side      <= hit_y;
            hit_cell_x    <= 5'($unsigned(mx));
            hit_cell_y    <= 5'($unsigned(my));
            wall_distance <= (dist_q > B_W'(DIST_MAX)) ? DIST_MAX : dist_q[21:0];
            no_wall       <= 1'b0;
          end else begin
            draw_start    <= 8'd0;
            draw_end      <= 8'd0;
            red           <= 8'd0;
            green         <= 8'd0;
            blue          <= 8'd0;
            hit_side      <= 1'b0;
            hit_cell_x    <= 5'd0;
            hit_cell_y    <= 5'd0;
            wall_distance <= DIST_MAX;
            no_wall       <= 1'b1;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `GDDR_AST_NOW(a_done_in_idle, done, !busy, "result strobe while busy")
  `GDDR_AST_NOW(a_nowall_fields, done && no_wall,
                wall_distance == DIST_MAX && hit_side == 1'b0 && red == 8'd0,
                "no-wall result carries wall fields")
  `GDDR_AST_NEXT(a_cast_goes_busy, start && !busy && mode && col_ok, busy,
                 "accepted cast did not start")
  `GDDR_AST_NOW(a_div_kick_quiet, div_go, !div_done, "divider kicked while finishing")
endmodule
